/* rtl/bgc_pkg.sv */
package bgc_pkg;

    // Command codes of an input item
    typedef enum logic [1:0] {
        CMD_NOTE_ON  = 2'd0,
        CMD_NOTE_OFF = 2'd1,
        CMD_CHECK    = 2'd2
    } cmd_t;

    // Tap phase of one button
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SHORT  = 2'd1,
        PH_DOUBLE = 2'd2,
        PH_TRIPLE = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        G_SHORT  = 2'd0,
        G_LONG   = 2'd1,
        G_DOUBLE = 2'd2,
        G_TRIPLE = 2'd3
    } gesture_t;

    // Configuration register indexes
    localparam logic [1:0] REG_DOUBLE_WINDOW = 2'd0;
    localparam logic [1:0] REG_TRIPLE_WINDOW = 2'd1;
    localparam logic [1:0] REG_LONG_PRESS    = 2'd2;

    localparam logic [15:0] DOUBLE_WINDOW_RST = 16'd300;
    localparam logic [15:0] TRIPLE_WINDOW_RST = 16'd300;
    localparam logic [15:0] LONG_PRESS_RST    = 16'd500;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  channel;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [31:0] time_now;
        logic        momentary;
        logic        triple_enabled;
        logic [15:0] debounce_ms;
        logic [15:0] long_override_ms;
        logic [15:0] double_override_ms;
        logic [15:0] triple_override_ms;
    } item_t;

    typedef struct packed {
        logic [3:0] out_channel;
        logic [6:0] out_note;
        gesture_t   gesture;
    } result_t;

    typedef struct packed {
        logic [15:0] double_window_ms;
        logic [15:0] triple_window_ms;
        logic [15:0] long_press_ms;
    } cfg_t;

    // One button entry of the state store
    typedef struct packed {
        logic        pressed;
        logic [31:0] press_start;
        logic [31:0] last_release;
        logic [31:0] first_tap;
        logic [31:0] second_tap;
        phase_t      phase;
        logic [31:0] expire;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Update unit to sequencer
    typedef struct packed {
        logic     wr;
        logic     fire;
        gesture_t gesture;
    } upd_ctl_t;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_EXEC  = 2'd2
    } state_t;

endpackage

/* rtl/bgc_ram.sv */
module bgc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/bgc_update.sv */
module bgc_update (
    input  bgc_pkg::entry_t   entry,
    input  bgc_pkg::item_t    item,
    input  bgc_pkg::cfg_t     cfg,
    output bgc_pkg::entry_t   new_entry,
    output bgc_pkg::upd_ctl_t ctl
);

    logic [31:0] now;
    logic [31:0] since_expire;
    logic [31:0] since_release;
    logic [31:0] hold;
    logic [31:0] since_second;
    logic [31:0] since_first;
    logic [15:0] eff_long;
    logic [15:0] eff_double;
    logic [15:0] eff_triple;
    logic        is_press;

    assign now           = item.time_now;
    assign since_expire  = now - entry.expire;
    assign since_release = now - entry.last_release;
    assign hold          = now - entry.press_start;
    assign since_second  = now - entry.second_tap;
    assign since_first   = now - entry.first_tap;

    assign eff_long   = (item.long_override_ms != 16'd0) ? item.long_override_ms
                                                         : cfg.long_press_ms;
    assign eff_double = (item.double_override_ms != 16'd0) ? item.double_override_ms
                                                           : cfg.double_window_ms;
    assign eff_triple = (item.triple_override_ms != 16'd0) ? item.triple_override_ms
                                                           : cfg.triple_window_ms;

    assign is_press = (item.cmd == bgc_pkg::CMD_NOTE_ON) && (item.velocity != 7'd0);

    always_comb
    begin
        new_entry   = entry;
        ctl.wr      = 1'b0;
        ctl.fire    = 1'b0;
        ctl.gesture = bgc_pkg::G_SHORT;
        case (item.cmd)
            bgc_pkg::CMD_CHECK:
            begin
                // fires once expiry lies in the past half of the time circle
                if (entry.phase != bgc_pkg::PH_IDLE && !since_expire[31])
                begin
                    ctl.wr  = 1'b1;
                    ctl.fire = 1'b1;
                    case (entry.phase)
                        bgc_pkg::PH_SHORT:  ctl.gesture = bgc_pkg::G_SHORT;
                        bgc_pkg::PH_DOUBLE: ctl.gesture = bgc_pkg::G_DOUBLE;
                        default:            ctl.gesture = bgc_pkg::G_TRIPLE;
                    endcase
                    new_entry.first_tap  = 32'd0;
                    new_entry.second_tap = 32'd0;
                    new_entry.phase      = bgc_pkg::PH_IDLE;
                    new_entry.expire     = 32'd0;
                end
            end
            bgc_pkg::CMD_NOTE_ON,
            bgc_pkg::CMD_NOTE_OFF:
            begin
                if (is_press)
                begin
                    if (entry.pressed)
                    begin
                        // repeated press re-arms the hold timer
                        ctl.wr                = 1'b1;
                        new_entry.press_start = now;
                    end
                    else if (!(item.debounce_ms != 16'd0 && entry.last_release != 32'd0 &&
                               since_release < {16'd0, item.debounce_ms}))
                    begin
                        ctl.wr                = 1'b1;
                        ctl.fire              = item.momentary;
                        new_entry.pressed     = 1'b1;
                        new_entry.press_start = now;
                    end
                end
                else if (entry.pressed)
                begin
                    ctl.wr            = 1'b1;
                    new_entry.pressed = 1'b0;
                    if (item.momentary)
                    begin
                        ctl.fire = 1'b1;
                    end
                    else
                    begin
                        new_entry.last_release = now;
                        if (hold >= {16'd0, eff_long})
                        begin
                            ctl.fire             = 1'b1;
                            ctl.gesture          = bgc_pkg::G_LONG;
                            new_entry.first_tap  = 32'd0;
                            new_entry.second_tap = 32'd0;
                            new_entry.phase      = bgc_pkg::PH_IDLE;
                            new_entry.expire     = 32'd0;
                        end
                        else if (entry.phase == bgc_pkg::PH_DOUBLE &&
                                 since_second <= {16'd0, eff_triple})
                        begin
                            ctl.fire             = 1'b1;
                            ctl.gesture          = bgc_pkg::G_TRIPLE;
                            new_entry.first_tap  = 32'd0;
                            new_entry.second_tap = 32'd0;
                            new_entry.phase      = bgc_pkg::PH_IDLE;
                            new_entry.expire     = 32'd0;
                        end
                        else if (entry.first_tap != 32'd0 &&
                                 since_first <= {16'd0, eff_double})
                        begin
                            if (!item.triple_enabled)
                            begin
                                ctl.fire             = 1'b1;
                                ctl.gesture          = bgc_pkg::G_DOUBLE;
                                new_entry.first_tap  = 32'd0;
                                new_entry.second_tap = 32'd0;
                                new_entry.phase      = bgc_pkg::PH_IDLE;
                                new_entry.expire     = 32'd0;
                            end
                            else
                            begin
                                new_entry.second_tap = now;
                                new_entry.phase      = bgc_pkg::PH_DOUBLE;
                                new_entry.expire     = now + {16'd0, eff_triple};
                            end
                        end
                        else
                        begin
                            new_entry.first_tap = now;
                            new_entry.phase     = bgc_pkg::PH_SHORT;
                            new_entry.expire    = now + {16'd0, eff_double};
                        end
                    end
                end
            end
            default:
            begin
                ctl.wr = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/button_gesture_classifier_core.sv */
// Channel   | Signals                                | Transfer
// ----------+----------------------------------------+-------------------------------
// item in   | start, busy, item                      | start && !busy at clk rise
// result    | result_valid, result                   | one-cycle strobe, no back-off
// config    | cfg_we, cfg_index, cfg_data            | cfg_we at clk rise, no wait
//
// The button entry of an accepted item is read from the state RAM, then updated
// and written back in ST_EXEC, as the RAM read is registered; busy is high there.
// The result strobe follows in the cycle after the update; the next item can
// already be taken in that cycle.
// After reset the RAM is cleared one entry a cycle, all NUM_CHANNELS *
// NOTES_PER_CHANNEL entries (2048 by default), with busy high throughout.
// The receiver cannot stall; results are never held.
module button_gesture_classifier_core #(
    parameter int NUM_CHANNELS      = 16,
    parameter int NOTES_PER_CHANNEL = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  bgc_pkg::item_t                      item,
    output logic                                result_valid,
    output bgc_pkg::result_t                    result,
    input  logic                                cfg_we,
    input  logic [bgc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bgc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int DEPTH = NUM_CHANNELS * NOTES_PER_CHANNEL;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    bgc_pkg::state_t   state_reg, state_next;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    bgc_pkg::item_t    item_reg;
    logic              in_range_reg;
    logic [AW-1:0]     addr_reg;
    bgc_pkg::cfg_t     cfg_reg;
    logic              result_valid_reg;
    bgc_pkg::result_t  result_reg;

    logic                     accept;
    logic                     in_range;
    logic [AW-1:0]            raddr;
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [bgc_pkg::ENTRY_W-1:0] ram_wdata;
    logic [bgc_pkg::ENTRY_W-1:0] ram_rdata;
    bgc_pkg::entry_t          entry;
    bgc_pkg::entry_t          new_entry;
    bgc_pkg::upd_ctl_t        ctl;
    logic                     exec_fire;

    // Button index; only meaningful when the button is in range
    assign in_range = ({1'b0, item.channel} < 5'(NUM_CHANNELS)) &&
                      ({1'b0, item.note} < 8'(NOTES_PER_CHANNEL));
    assign raddr    = AW'(item.channel) * AW'(NOTES_PER_CHANNEL) + AW'(item.note);

    assign busy   = (state_reg != bgc_pkg::ST_IDLE);
    assign accept = start && !busy;

    // Sequencer: clear sweep, then read / update-write per item
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            bgc_pkg::ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = bgc_pkg::ST_IDLE;
                end
            end
            bgc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = bgc_pkg::ST_EXEC;
                end
            end
            bgc_pkg::ST_EXEC:
            begin
                state_next = bgc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bgc_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bgc_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // Item capture for the update cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg     <= item;
            in_range_reg <= in_range;
            addr_reg     <= raddr;
        end
    end

    // Global registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.double_window_ms <= bgc_pkg::DOUBLE_WINDOW_RST;
            cfg_reg.triple_window_ms <= bgc_pkg::TRIPLE_WINDOW_RST;
            cfg_reg.long_press_ms    <= bgc_pkg::LONG_PRESS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bgc_pkg::REG_DOUBLE_WINDOW: cfg_reg.double_window_ms <= cfg_data;
                bgc_pkg::REG_TRIPLE_WINDOW: cfg_reg.triple_window_ms <= cfg_data;
                bgc_pkg::REG_LONG_PRESS:    cfg_reg.long_press_ms    <= cfg_data;
                default:                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Write port: zero sweep during clear, else update write-back. The next
    // read is issued after the write's cycle, so no forwarding is needed.
    always_comb
    begin
        if (state_reg == bgc_pkg::ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = (state_reg == bgc_pkg::ST_EXEC) && in_range_reg && ctl.wr;
            ram_waddr = addr_reg;
            ram_wdata = new_entry;
        end
    end

    bgc_ram #(
        .WIDTH (bgc_pkg::ENTRY_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    assign entry = bgc_pkg::entry_t'(ram_rdata);

    bgc_update u_update (
        .entry     (entry),
        .item      (item_reg),
        .cfg       (cfg_reg),
        .new_entry (new_entry),
        .ctl       (ctl)
    );

    assign exec_fire = (state_reg == bgc_pkg::ST_EXEC) && in_range_reg && ctl.fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= exec_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            result_reg.out_channel <= item_reg.channel;
            result_reg.out_note    <= item_reg.note;
            result_reg.gesture     <= ctl.gesture;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* tb/sv/gesture_checker.sv */
module gesture_checker #(
    parameter int NUM_CHANNELS      = 16,
    parameter int NOTES_PER_CHANNEL = 128
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  bgc_pkg::item_t                    item,
    input  logic                              result_valid,
    input  bgc_pkg::result_t                  result,
    input  logic                              cfg_we,
    input  logic [bgc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bgc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output int                                fail_count,
    output int                                pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import bgc_pkg::*;

    localparam int BTN_COUNT = NUM_CHANNELS * NOTES_PER_CHANNEL;

    // shadow of the button store
    logic        held       [BTN_COUNT];
    logic [31:0] t_press    [BTN_COUNT];
    logic [31:0] t_release  [BTN_COUNT];
    logic [31:0] t_first    [BTN_COUNT];
    logic [31:0] t_second   [BTN_COUNT];
    phase_t      tap_state  [BTN_COUNT];
    logic [31:0] t_expire   [BTN_COUNT];

    logic [15:0] win_double, win_triple, hold_long;

    result_t gestures_due [$];
    result_t want;
    logic    fires;
    result_t gest;
    int      mism = 0;

    function automatic void clear_taps(input int b);
        t_first[b]   = '0;
        t_second[b]  = '0;
        tap_state[b] = PH_IDLE;
        t_expire[b]  = '0;
    endfunction

    // predicted gesture, if any, for one accepted transfer
    function automatic void classify_event(input item_t it, output logic hit,
                                           output result_t g);
        int          b;
        logic [31:0] now, dur, diff, elong, edbl, etri;
        logic        release_ev;
        hit = 1'b0;
        g = '0;
        g.out_channel = it.channel;
        g.out_note = it.note;
        g.gesture = G_SHORT;
        if (it.channel >= NUM_CHANNELS || it.note >= NOTES_PER_CHANNEL) return;
        b = it.channel * NOTES_PER_CHANNEL + it.note;
        now = it.time_now;
        release_ev = 1'b0;
        case (it.cmd)
            CMD_CHECK: begin
                if (tap_state[b] == PH_IDLE) return;
                diff = now - t_expire[b];
                if (diff[31]) return;
                case (tap_state[b])
                    PH_SHORT:  g.gesture = G_SHORT;
                    PH_DOUBLE: g.gesture = G_DOUBLE;
                    default:   g.gesture = G_TRIPLE;
                endcase
                clear_taps(b);
                hit = 1'b1;
                return;
            end
            CMD_NOTE_ON: begin
                if (it.velocity == 0) release_ev = 1'b1;
                else begin
                    if (held[b]) begin
                        t_press[b] = now;
                        return;
                    end
                    diff = now - t_release[b];
                    if (it.debounce_ms != 0 && t_release[b] != 0 &&
                        diff < {16'd0, it.debounce_ms}) return;
                    held[b] = 1'b1;
                    t_press[b] = now;
                    hit = it.momentary;
                    return;
                end
            end
            CMD_NOTE_OFF: release_ev = 1'b1;
            default: return;
        endcase
        if (!release_ev || !held[b]) return;
        held[b] = 1'b0;
        if (it.momentary) begin
            hit = 1'b1;
            return;
        end
        dur = now - t_press[b];
        t_release[b] = now;
        elong = {16'd0, (it.long_override_ms != 0) ? it.long_override_ms : hold_long};
        edbl = {16'd0, (it.double_override_ms != 0) ? it.double_override_ms : win_double};
        etri = {16'd0, (it.triple_override_ms != 0) ? it.triple_override_ms : win_triple};
        if (dur >= elong) begin
            clear_taps(b);
            g.gesture = G_LONG;
            hit = 1'b1;
            return;
        end
        diff = now - t_second[b];
        if (tap_state[b] == PH_DOUBLE && diff <= etri) begin
            clear_taps(b);
            g.gesture = G_TRIPLE;
            hit = 1'b1;
            return;
        end
        diff = now - t_first[b];
        if (t_first[b] != 0 && diff <= edbl) begin
            if (!it.triple_enabled) begin
                clear_taps(b);
                g.gesture = G_DOUBLE;
                hit = 1'b1;
                return;
            end
            t_second[b] = now;
            tap_state[b] = PH_DOUBLE;
            t_expire[b] = now + etri;
            return;
        end
        t_first[b] = now;
        tap_state[b] = PH_SHORT;
        t_expire[b] = now + edbl;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < BTN_COUNT; i++) begin
                held[i] = 1'b0;
                t_press[i] = '0;
                t_release[i] = '0;
                clear_taps(i);
            end
            win_double = DOUBLE_WINDOW_RST;
            win_triple = TRIPLE_WINDOW_RST;
            hold_long = LONG_PRESS_RST;
            gestures_due.delete();
            pending <= 0;
            fail_count <= mism;
        end else begin
            // strobe first: it belongs to an earlier transfer
            if (result_valid) begin
                if (gestures_due.size() == 0) begin
                    $error("unexpected gesture: ch %0d note %0d gesture %0d",
                           result.out_channel, result.out_note, result.gesture);
                    mism++;
                end else begin
                    want = gestures_due.pop_front();
                    if (result.out_channel !== want.out_channel) begin
                        $error("out_channel mismatch: expected %0d, actual %0d",
                               want.out_channel, result.out_channel);
                        mism++;
                    end
                    if (result.out_note !== want.out_note) begin
                        $error("out_note mismatch: expected %0d, actual %0d",
                               want.out_note, result.out_note);
                        mism++;
                    end
                    if (result.gesture !== want.gesture) begin
                        $error("gesture mismatch: expected %0d, actual %0d",
                               want.gesture, result.gesture);
                        mism++;
                    end
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_DOUBLE_WINDOW: win_double = cfg_data;
                    REG_TRIPLE_WINDOW: win_triple = cfg_data;
                    REG_LONG_PRESS:    hold_long = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy) begin
                classify_event(item, fires, gest);
                if (fires) gestures_due.push_back(gest);
            end
            pending <= gestures_due.size();
            fail_count <= mism;
        end
    end

endmodule

/* tb/sv/tb_top.sv */
// Stimulus and verdict for the button gesture classifier.
// The checker beside the block does all prediction and comparison; this module
// only drives transfers and register writes and reads back the failure count.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bgc_pkg::*;

    // codes outside the package enums, still reachable through the 2-bit fields
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam int POOL_N      = 6;
    localparam int PHASE_ITEMS = 125;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    item_t                  item;
    logic                   result_valid;
    result_t                result;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     fail_count;
    int                     pending;

    // copy of the register values, used only to aim hold times and tap gaps
    logic [15:0] dbl_reg = DOUBLE_WINDOW_RST;
    logic [15:0] tri_reg = TRIPLE_WINDOW_RST;
    logic [15:0] long_reg = LONG_PRESS_RST;

    logic [31:0] now_ms = 32'd0;     // running millisecond stamp
    int          items_sent = 0;
    bit          burst = 1'b0;       // back-to-back stretch, no sender gaps
    logic [3:0]  pool_ch [POOL_N];   // small set of buttons that get hammered
    logic [6:0]  pool_nt [POOL_N];

    button_gesture_classifier_core dut (.*);
    gesture_checker chk (.*);

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop in case a transfer or an expected gesture never shows up
    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic item_t ev(input logic [1:0] cmd, input logic [3:0] ch,
                                 input logic [6:0] nt, input logic [31:0] t);
        item_t it;
        it = '0;
        it.cmd = cmd;
        it.channel = ch;
        it.note = nt;
        it.velocity = 7'd100;
        it.time_now = t;
        return it;
    endfunction

    // per-button time: half the time "use the register", else small or any
    function automatic logic [15:0] pick_ms();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return 16'd0;
        if (r < 8) return 16'($urandom_range(1, 600));
        return 16'($urandom_range(0, 65535));
    endfunction

    // One transfer: random sender gap (or none in a burst), then hold start
    // until the edge where busy is low. start stays high into the next
    // transfer when there is no gap, so it is never dropped and raised again.
    task automatic send(input item_t it);
        int gap;
        if ($urandom_range(0, 39) == 0) burst = !burst;
        gap = burst ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        do @(posedge clk); while (busy);
        items_sent++;
    endtask

    // Wait until every predicted gesture has arrived and the block is idle,
    // then wait on for an item that ends without a strobe.
    task automatic drain();
        start <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0 || busy) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Registers are only touched from an idle block (after drain).
    task automatic set_regs(input logic [15:0] dw, input logic [15:0] tw,
                            input logic [15:0] lp);
        cfg_we <= 1'b1;
        cfg_index <= REG_DOUBLE_WINDOW;
        cfg_data <= dw;
        @(posedge clk);
        cfg_index <= REG_TRIPLE_WINDOW;
        cfg_data <= tw;
        @(posedge clk);
        cfg_index <= REG_LONG_PRESS;
        cfg_data <= lp;
        @(posedge clk);
        // index with no register behind it: must leave the others alone
        cfg_index <= REG_UNUSED;
        cfg_data <= 16'($urandom_range(0, 65535));
        @(posedge clk);
        cfg_we <= 1'b0;
        dbl_reg = dw;
        tri_reg = tw;
        long_reg = lp;
    endtask

    task automatic press_release(input logic [3:0] ch, input logic [6:0] nt,
                                 input logic [31:0] t_on, input logic [31:0] t_off,
                                 input logic trip);
        item_t it;
        it = ev(CMD_NOTE_ON, ch, nt, t_on);
        it.triple_enabled = trip;
        send(it);
        it.cmd = CMD_NOTE_OFF;
        it.time_now = t_off;
        send(it);
    endtask

    // A well-formed tap sequence on one button with one set of overrides:
    // one to four taps, holds mostly short of the long time, gaps mostly
    // inside the window, then one or two expiry checks.
    task automatic play_gesture(input logic [3:0] ch, input logic [6:0] nt);
        item_t       prof;
        item_t       it;
        logic [31:0] elong, edbl, etri, w, hold, cap;
        int          taps;
        prof = ev(CMD_NOTE_ON, ch, nt, now_ms);
        prof.momentary = ($urandom_range(0, 7) == 0);
        prof.triple_enabled = 1'($urandom_range(0, 1));
        prof.debounce_ms = ($urandom_range(0, 3) == 0) ? pick_ms() : 16'd0;
        prof.long_override_ms = pick_ms();
        prof.double_override_ms = pick_ms();
        prof.triple_override_ms = pick_ms();
        elong = {16'd0, (prof.long_override_ms != 0) ? prof.long_override_ms : long_reg};
        edbl = {16'd0, (prof.double_override_ms != 0) ? prof.double_override_ms : dbl_reg};
        etri = {16'd0, (prof.triple_override_ms != 0) ? prof.triple_override_ms : tri_reg};
        taps = ($urandom_range(0, 9) == 0) ? 4 : $urandom_range(1, 3);
        w = edbl;
        for (int k = 0; k < taps; k++) begin
            w = (k == 0) ? edbl : etri;
            it = prof;
            it.velocity = 7'($urandom_range(1, 127));
            it.time_now = now_ms;
            send(it);
            // repeated press re-arms the hold start
            if ($urandom_range(0, 9) == 0) begin
                now_ms += $urandom_range(0, 100);
                it.time_now = now_ms;
                send(it);
            end
            if (elong == 0 || $urandom_range(0, 4) == 0) begin
                hold = elong + $urandom_range(0, 300);
            end else begin
                cap = (elong - 1 < w / 2) ? elong - 1 : w / 2;
                hold = $urandom_range(0, cap);
            end
            now_ms += hold;
            it.time_now = now_ms;
            // release either as note off or as note on with zero velocity
            if ($urandom_range(0, 4) == 0) begin
                it.cmd = CMD_NOTE_ON;
                it.velocity = 7'd0;
            end else begin
                it.cmd = CMD_NOTE_OFF;
                it.velocity = 7'($urandom_range(0, 127));
            end
            send(it);
            if ($urandom_range(0, 3) == 0) now_ms += w + $urandom_range(1, 400);
            else now_ms += $urandom_range(0, w / 2);
        end
        it = prof;
        it.cmd = CMD_CHECK;
        it.time_now = now_ms;
        send(it);
        if ($urandom_range(0, 1) == 0) begin
            it.time_now = now_ms + w + $urandom_range(0, 50);
            send(it);
        end
    endtask

    // Junk and broken sequences: any command, any button, any field value.
    task automatic send_noise();
        item_t it;
        int    p;
        p = $urandom_range(0, POOL_N - 1);
        it.cmd = 2'($urandom_range(0, 3));
        it.channel = ($urandom_range(0, 1) == 0) ? pool_ch[p] : 4'($urandom_range(0, 15));
        it.note = ($urandom_range(0, 1) == 0) ? pool_nt[p] : 7'($urandom_range(0, 127));
        it.velocity = 7'($urandom_range(0, 127));
        it.time_now = ($urandom_range(0, 3) == 0) ? 32'($urandom()) : now_ms;
        it.momentary = 1'($urandom_range(0, 1));
        it.triple_enabled = 1'($urandom_range(0, 1));
        it.debounce_ms = 16'($urandom_range(0, 65535));
        it.long_override_ms = 16'($urandom_range(0, 65535));
        it.double_override_ms = 16'($urandom_range(0, 65535));
        it.triple_override_ms = 16'($urandom_range(0, 65535));
        send(it);
    endtask

    // Expiry sweep over the whole pool at the current stamp.
    task automatic sweep_pool();
        for (int i = 0; i < POOL_N; i++) send(ev(CMD_CHECK, pool_ch[i], pool_nt[i], now_ms));
    endtask

    task automatic run_phase(input int n);
        int stop_at;
        int r;
        int p;
        stop_at = items_sent + n;
        pool_ch[0] = 4'd0;
        pool_nt[0] = 7'd0;
        pool_ch[1] = 4'd15;
        pool_nt[1] = 7'd127;
        for (int i = 2; i < POOL_N; i++) begin
            pool_ch[i] = 4'($urandom_range(0, 15));
            pool_nt[i] = 7'($urandom_range(0, 127));
        end
        while (items_sent < stop_at) begin
            r = $urandom_range(0, 99);
            p = $urandom_range(0, POOL_N - 1);
            if (r < 70) play_gesture(pool_ch[p], pool_nt[p]);
            else if (r < 78) play_gesture(4'($urandom_range(0, 15)),
                                          7'($urandom_range(0, 127)));
            else if (r < 92) send_noise();
            else sweep_pool();
            // move the stamp on; now and then jump anywhere or close to the wrap
            r = $urandom_range(0, 19);
            if (r == 0) now_ms = $urandom();
            else if (r == 1) now_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
            else now_ms += $urandom_range(0, 3000);
        end
    endtask

    initial begin
        item_t it;
        rst_n <= 1'b0;
        start <= 1'b0;
        item <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // the block clears its store after reset with busy high
        drain();

        // ---- directed part, reset register values ----
        // first tap, check one ms early (no fire), then exactly at expiry
        press_release(4'd15, 7'd127, 32'd1000, 32'd1100, 1'b0);
        send(ev(CMD_CHECK, 4'd15, 7'd127, 32'd1399));
        send(ev(CMD_CHECK, 4'd15, 7'd127, 32'd1400));
        // hold exactly the long time
        press_release(4'd15, 7'd127, 32'd2000, 32'd2500, 1'b0);
        // double without a triple action
        press_release(4'd15, 7'd127, 32'd3000, 32'd3050, 1'b0);
        press_release(4'd15, 7'd127, 32'd3100, 32'd3150, 1'b0);
        // triple: second tap waits, third one fires
        press_release(4'd15, 7'd127, 32'd4000, 32'd4050, 1'b1);
        press_release(4'd15, 7'd127, 32'd4100, 32'd4150, 1'b1);
        press_release(4'd15, 7'd127, 32'd4200, 32'd4250, 1'b1);
        // momentary: short on press and on release
        it = ev(CMD_NOTE_ON, 4'd0, 7'd0, 32'd5000);
        it.momentary = 1'b1;
        send(it);
        it.cmd = CMD_NOTE_OFF;
        send(it);
        // release of a button that is not pressed
        send(ev(CMD_NOTE_OFF, 4'd0, 7'd0, 32'd5100));
        // press, repeated press re-arms, zero velocity note on releases
        it = ev(CMD_NOTE_ON, 4'd0, 7'd0, 32'd6000);
        it.velocity = 7'd1;
        send(it);
        it.time_now = 32'd6300;
        send(it);
        it.velocity = 7'd0;
        it.time_now = 32'd6350;
        send(it);
        // press inside the debounce gap is dropped
        it = ev(CMD_NOTE_ON, 4'd0, 7'd0, 32'd6360);
        it.debounce_ms = 16'd100;
        send(it);
        // unused command with every field at its top value
        it = ev(CMD_UNUSED, 4'd15, 7'd127, 32'hFFFF_FFFF);
        it.velocity = 7'd127;
        it.momentary = 1'b1;
        it.triple_enabled = 1'b1;
        it.debounce_ms = 16'hFFFF;
        it.long_override_ms = 16'hFFFF;
        it.double_override_ms = 16'hFFFF;
        it.triple_override_ms = 16'hFFFF;
        send(it);
        // hold across the 32-bit wrap, release lands on stamp zero
        press_release(4'd15, 7'd127, 32'hFFFF_FFF0, 32'd0, 1'b0);
        press_release(4'd15, 7'd127, 32'd10, 32'd20, 1'b0);

        // ---- random part, one phase per register setting ----
        now_ms = 32'd10_000;
        run_phase(PHASE_ITEMS);
        drain();
        set_regs(16'd1, 16'd1, 16'd1);
        run_phase(PHASE_ITEMS);
        drain();
        set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_phase(PHASE_ITEMS);
        drain();
        // zero registers are used as written
        set_regs(16'd0, 16'd0, 16'd0);
        run_phase(PHASE_ITEMS);
        drain();
        set_regs(16'($urandom_range(1, 2000)), 16'($urandom_range(1, 2000)),
                 16'($urandom_range(1, 2000)));
        run_phase(PHASE_ITEMS);

        drain();
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
